### hdl/assert_macros.svh
// Assertion macros used by the port checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

### hdl/clpc_pkg.sv
// Types, constants and helper functions of the character LCD controller.
`timescale 1ns / 1ps
`default_nettype none

package clpc_pkg;

  // Character buffer and power-on wait sizing.
  localparam int BUF_DEPTH      = 32;
  localparam int BUF_AW         = $clog2(BUF_DEPTH);
  localparam int POWER_ON_TICKS = 16;
  localparam logic [4:0] POT_LAST = 5'(POWER_ON_TICKS - 1);

  // Item modes.
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_START    = 3'd1;
  localparam logic [2:0] MODE_LOAD     = 3'd2;
  localparam logic [2:0] MODE_WRITE    = 3'd3;
  localparam logic [2:0] MODE_WRITE_XY = 3'd4;
  localparam logic [2:0] MODE_CLEAR    = 3'd5;
  localparam logic [2:0] MODE_CURSOR   = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DISPLAY_ON    = 3'd0;
  localparam logic [2:0] CFG_CURSOR_ON     = 3'd1;
  localparam logic [2:0] CFG_BLINK_ON      = 3'd2;
  localparam logic [2:0] CFG_ADDR_INC      = 3'd3;
  localparam logic [2:0] CFG_DISPLAY_SHIFT = 3'd4;
  localparam logic [2:0] CFG_EIGHT_BIT     = 3'd5;
  localparam logic [2:0] CFG_TWO_LINES     = 3'd6;
  localparam logic [2:0] CFG_TALL_FONT     = 3'd7;

  // Status codes shown on the result ports.
  localparam logic [1:0] LCD_ST_OFF  = 2'd0;
  localparam logic [1:0] LCD_ST_INIT = 2'd1;
  localparam logic [1:0] LCD_ST_OPER = 2'd2;
  localparam logic [1:0] REQ_ST_NONE = 2'd0;
  localparam logic [1:0] REQ_ST_BUSY = 2'd1;
  localparam logic [1:0] REQ_ST_DONE = 2'd2;

  // LCD command bytes and line base addresses.
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h04;
  localparam logic [7:0] CMD_DISPLAY   = 8'h08;
  localparam logic [7:0] CMD_FUNCTION  = 8'h20;
  localparam logic [7:0] LINE0_BASE    = 8'h80;
  localparam logic [7:0] LINE1_BASE    = 8'hC0;

  typedef enum logic [2:0] {
    TOP_OFF  = 3'b001,
    TOP_INIT = 3'b010,
    TOP_OPER = 3'b100
  } top_state_t;

  typedef enum logic [4:0] {
    INIT_WAIT  = 5'b00001,
    INIT_FUNC  = 5'b00010,
    INIT_DISP  = 5'b00100,
    INIT_CLEAR = 5'b01000,
    INIT_ENTRY = 5'b10000
  } init_state_t;

  typedef enum logic [2:0] {
    REQ_NONE = 3'b001,
    REQ_BUSY = 3'b010,
    REQ_DONE = 3'b100
  } req_state_t;

  typedef enum logic [2:0] {
    XY_READY  = 3'b001,
    XY_CURSOR = 3'b010,
    XY_CHARS  = 3'b100
  } xy_state_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_CURSOR = 2'd2,
    KIND_XY     = 2'd3
  } req_kind_t;

  // Enable strobe sequencer state together with the pin levels it drives.
  typedef struct packed {
    logic       low;
    logic       started;
    logic       rs;
    logic       en;
    logic [7:0] data;
  } strb_t;

  // One result item.
  typedef struct packed {
    logic       rs;
    logic       en;
    logic [7:0] data;
    logic [1:0] lcd_status;
    logic [1:0] req_status;
    logic       done;
  } res_t;

  // First call raises E with the new byte; second call drops E.
  function automatic strb_t strobe_f(strb_t s, logic rs, logic [7:0] b);
    strb_t o;
    o = s;
    if (!s.low) begin
      o.data    = b;
      o.rs      = rs;
      o.en      = 1'b1;
      o.low     = 1'b1;
      o.started = 1'b1;
    end else begin
      o.en  = 1'b0;
      o.low = 1'b0;
    end
    return o;
  endfunction

  function automatic logic strobe_done_f(strb_t s);
    return !s.low && s.started;
  endfunction

  function automatic logic [1:0] lcd_code_f(top_state_t t);
    logic [1:0] c;
    case (t)
      TOP_INIT: c = LCD_ST_INIT;
      TOP_OPER: c = LCD_ST_OPER;
      default:  c = LCD_ST_OFF;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] req_code_f(req_state_t r);
    logic [1:0] c;
    case (r)
      REQ_BUSY: c = REQ_ST_BUSY;
      REQ_DONE: c = REQ_ST_DONE;
      default:  c = REQ_ST_NONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/char_lcd_parallel_controller_top.sv
// Each result is registered in the output stage: in the main register or, while that is held, in the skid register.
// Throughput: one item per cycle while the skid register is empty; each item is a single read-modify-write of the
// controller registers, with the character buffer read port prefetching the next byte.
// A two-entry output stage lets input keep flowing while a result waits to be taken.
// Reset (synchronous, active low) clears all control state and the output stage;
// the character buffer is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_parallel_controller_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_mode,
  input  wire logic [4:0] in_char_index,
  input  wire logic [7:0] in_char_value,
  input  wire logic [5:0] in_length,
  input  wire logic [5:0] in_column,
  input  wire logic [1:0] in_row,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_reg_select,
  output logic            out_read_write,
  output logic            out_enable_pin,
  output logic [7:0]      out_data_bus,
  output logic [1:0]      out_lcd_status,
  output logic [1:0]      out_request_status,
  output logic            out_request_done,
  // Configuration write channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic       cfg_data
);

  // Configuration registers.
  logic cfg_display_on_r, cfg_cursor_on_r, cfg_blink_on_r, cfg_addr_inc_r;
  logic cfg_display_shift_r, cfg_eight_bit_r, cfg_two_lines_r, cfg_tall_font_r;

  // Controller state.
  clpc_pkg::top_state_t  top_r, top_nxt;
  clpc_pkg::init_state_t init_r, init_nxt;
  clpc_pkg::req_state_t  req_r, req_nxt;
  clpc_pkg::xy_state_t   xy_r, xy_nxt;
  clpc_pkg::req_kind_t   kind_r, kind_nxt;
  clpc_pkg::strb_t       strb_r, strb_nxt;
  logic [4:0] pot_r, pot_nxt;
  logic [5:0] ptr_r, ptr_nxt;
  logic [5:0] len_r, len_nxt;
  logic [5:0] col_r, col_nxt;
  logic [1:0] row_r, row_nxt;

  // Character buffer and its registered read data.
  logic [7:0] buf_mem [clpc_pkg::BUF_DEPTH];
  logic [7:0] rd_r;
  logic       mem_we;
  logic [clpc_pkg::BUF_AW-1:0] mem_raddr;

  // Output stage.
  clpc_pkg::res_t out_r, skid_r, res;
  logic out_valid_r, skid_valid_r;
  logic in_fire, out_fire, pulse, fin, free_now;

  // Strobe candidates for each kind of byte.
  clpc_pkg::strb_t func_strb, disp_strb, clear_strb, entry_strb, char_strb, cursor_strb;
  logic [7:0] func_byte, disp_byte, entry_byte;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;
  assign free_now  = (req_r != clpc_pkg::REQ_BUSY);

  // Command bytes built from the configuration bits.
  assign func_byte  = clpc_pkg::CMD_FUNCTION | {3'b000, cfg_eight_bit_r, cfg_two_lines_r,
                                                cfg_tall_font_r, 2'b00};
  assign disp_byte  = clpc_pkg::CMD_DISPLAY | {5'b00000, cfg_display_on_r, cfg_cursor_on_r,
                                               cfg_blink_on_r};
  assign entry_byte = clpc_pkg::CMD_ENTRY | {6'b000000, cfg_addr_inc_r, cfg_display_shift_r};

  assign func_strb  = clpc_pkg::strobe_f(strb_r, 1'b0, func_byte);
  assign disp_strb  = clpc_pkg::strobe_f(strb_r, 1'b0, disp_byte);
  assign clear_strb = clpc_pkg::strobe_f(strb_r, 1'b0, clpc_pkg::CMD_CLEAR);
  assign entry_strb = clpc_pkg::strobe_f(strb_r, 1'b0, entry_byte);
  assign char_strb  = clpc_pkg::strobe_f(strb_r, 1'b1, rd_r);

  // Rows past the second send nothing and leave the strobe untouched.
  always_comb begin
    case (row_r)
      2'd0:    cursor_strb = clpc_pkg::strobe_f(strb_r, 1'b0,
                                                clpc_pkg::LINE0_BASE + {2'b00, col_r});
      2'd1:    cursor_strb = clpc_pkg::strobe_f(strb_r, 1'b0,
                                                clpc_pkg::LINE1_BASE + {2'b00, col_r});
      default: cursor_strb = strb_r;
    endcase
  end

  // Next-state logic for one accepted item.
  always_comb begin
    top_nxt  = top_r;
    init_nxt = init_r;
    req_nxt  = req_r;
    xy_nxt   = xy_r;
    kind_nxt = kind_r;
    strb_nxt = strb_r;
    pot_nxt  = pot_r;
    ptr_nxt  = ptr_r;
    len_nxt  = len_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    mem_we   = 1'b0;
    pulse    = 1'b0;
    fin      = 1'b0;
    if (in_fire) begin
      case (in_mode)
        clpc_pkg::MODE_TICK: begin
          if (top_r == clpc_pkg::TOP_INIT) begin
            case (init_r)
              clpc_pkg::INIT_WAIT: begin
                if (pot_r == clpc_pkg::POT_LAST) init_nxt = clpc_pkg::INIT_FUNC;
                pot_nxt = pot_r + 5'd1;
              end
              clpc_pkg::INIT_FUNC: begin
                strb_nxt = func_strb;
                if (clpc_pkg::strobe_done_f(func_strb)) init_nxt = clpc_pkg::INIT_DISP;
              end
              clpc_pkg::INIT_DISP: begin
                strb_nxt = disp_strb;
                if (clpc_pkg::strobe_done_f(disp_strb)) init_nxt = clpc_pkg::INIT_CLEAR;
              end
              clpc_pkg::INIT_CLEAR: begin
                strb_nxt = clear_strb;
                if (clpc_pkg::strobe_done_f(clear_strb)) init_nxt = clpc_pkg::INIT_ENTRY;
              end
              default: begin
                // Entry mode is the last init byte; it stays here for good.
                strb_nxt = entry_strb;
                if (clpc_pkg::strobe_done_f(entry_strb)) top_nxt = clpc_pkg::TOP_OPER;
              end
            endcase
          end else if (top_r == clpc_pkg::TOP_OPER) begin
            if (req_r == clpc_pkg::REQ_DONE) req_nxt = clpc_pkg::REQ_NONE;
            if (req_r == clpc_pkg::REQ_BUSY) begin
              case (kind_r)
                clpc_pkg::KIND_CLEAR: begin
                  strb_nxt = clear_strb;
                  fin      = clpc_pkg::strobe_done_f(clear_strb);
                end
                clpc_pkg::KIND_XY: begin
                  case (xy_r)
                    clpc_pkg::XY_READY: xy_nxt = clpc_pkg::XY_CURSOR;
                    clpc_pkg::XY_CURSOR: begin
                      strb_nxt = cursor_strb;
                      if (clpc_pkg::strobe_done_f(cursor_strb)) xy_nxt = clpc_pkg::XY_CHARS;
                    end
                    default: begin
                      strb_nxt = char_strb;
                      if (clpc_pkg::strobe_done_f(char_strb)) begin
                        ptr_nxt = ptr_r + 6'd1;
                        if (ptr_nxt == len_r) xy_nxt = clpc_pkg::XY_READY;
                      end
                    end
                  endcase
                  fin = (ptr_nxt == len_r);
                end
                clpc_pkg::KIND_WRITE: begin
                  strb_nxt = char_strb;
                  if (clpc_pkg::strobe_done_f(char_strb)) begin
                    ptr_nxt = ptr_r + 6'd1;
                    if (ptr_nxt == len_r) xy_nxt = clpc_pkg::XY_READY;
                  end
                  fin = (ptr_nxt == len_r);
                end
                default: begin
                  strb_nxt = cursor_strb;
                  fin      = clpc_pkg::strobe_done_f(cursor_strb);
                end
              endcase
              if (fin) req_nxt = clpc_pkg::REQ_DONE;
              pulse = fin;
            end
          end
        end
        clpc_pkg::MODE_START: top_nxt = clpc_pkg::TOP_INIT;
        clpc_pkg::MODE_LOAD:  mem_we = 1'b1;
        clpc_pkg::MODE_WRITE, clpc_pkg::MODE_WRITE_XY: begin
          if (free_now && (in_length != 6'd0)) begin
            req_nxt  = clpc_pkg::REQ_BUSY;
            kind_nxt = (in_mode == clpc_pkg::MODE_WRITE) ? clpc_pkg::KIND_WRITE
                                                         : clpc_pkg::KIND_XY;
            ptr_nxt  = 6'd0;
            len_nxt  = in_length;
            if (in_mode == clpc_pkg::MODE_WRITE_XY) begin
              col_nxt = in_column;
              row_nxt = in_row;
            end
          end
        end
        clpc_pkg::MODE_CLEAR: begin
          if (free_now) begin
            req_nxt  = clpc_pkg::REQ_BUSY;
            kind_nxt = clpc_pkg::KIND_CLEAR;
          end
        end
        clpc_pkg::MODE_CURSOR: begin
          if (free_now) begin
            req_nxt  = clpc_pkg::REQ_BUSY;
            kind_nxt = clpc_pkg::KIND_CURSOR;
            col_nxt  = in_column;
            row_nxt  = in_row;
          end
        end
        default: ;
      endcase
    end
  end

  // Result item formed from the updated state.
  always_comb begin
    res.rs         = strb_nxt.rs;
    res.en         = strb_nxt.en;
    res.data       = strb_nxt.data;
    res.lcd_status = clpc_pkg::lcd_code_f(top_nxt);
    res.req_status = clpc_pkg::req_code_f(req_nxt);
    res.done       = pulse;
  end

  // Controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= clpc_pkg::TOP_OFF;
      init_r <= clpc_pkg::INIT_WAIT;
      req_r  <= clpc_pkg::REQ_NONE;
      xy_r   <= clpc_pkg::XY_READY;
      kind_r <= clpc_pkg::KIND_WRITE;
      strb_r <= '0;
      pot_r  <= '0;
      ptr_r  <= '0;
      len_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      top_r  <= top_nxt;
      init_r <= init_nxt;
      req_r  <= req_nxt;
      xy_r   <= xy_nxt;
      kind_r <= kind_nxt;
      strb_r <= strb_nxt;
      pot_r  <= pot_nxt;
      ptr_r  <= ptr_nxt;
      len_r  <= len_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_display_on_r    <= 1'b1;
      cfg_cursor_on_r     <= 1'b0;
      cfg_blink_on_r      <= 1'b0;
      cfg_addr_inc_r      <= 1'b1;
      cfg_display_shift_r <= 1'b0;
      cfg_eight_bit_r     <= 1'b1;
      cfg_two_lines_r     <= 1'b1;
      cfg_tall_font_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clpc_pkg::CFG_DISPLAY_ON:    cfg_display_on_r    <= cfg_data;
        clpc_pkg::CFG_CURSOR_ON:     cfg_cursor_on_r     <= cfg_data;
        clpc_pkg::CFG_BLINK_ON:      cfg_blink_on_r      <= cfg_data;
        clpc_pkg::CFG_ADDR_INC:      cfg_addr_inc_r      <= cfg_data;
        clpc_pkg::CFG_DISPLAY_SHIFT: cfg_display_shift_r <= cfg_data;
        clpc_pkg::CFG_EIGHT_BIT:     cfg_eight_bit_r     <= cfg_data;
        clpc_pkg::CFG_TWO_LINES:     cfg_two_lines_r     <= cfg_data;
        clpc_pkg::CFG_TALL_FONT:     cfg_tall_font_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Buffer port: the read always targets the next pointer so that rd_r holds
  // the byte at the current pointer; a load to that slot is forwarded.
  assign mem_raddr = ptr_nxt[clpc_pkg::BUF_AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[in_char_index] <= in_char_value;
    end
    if (mem_we && (in_char_index == mem_raddr)) begin
      rd_r <= in_char_value;
    end else begin
      rd_r <= buf_mem[mem_raddr];
    end
  end

  // Two-entry output stage: main register plus skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) out_r <= skid_r;
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reg_select     = out_r.rs;
  assign out_read_write     = 1'b0;
  assign out_enable_pin     = out_r.en;
  assign out_data_bus       = out_r.data;
  assign out_lcd_status     = out_r.lcd_status;
  assign out_request_status = out_r.req_status;
  assign out_request_done   = out_r.done;

endmodule

`default_nettype wire

### hdl/clpc_checker.sv
// Port-level checker for the character LCD controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clpc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_read_write,
  input wire logic [7:0] out_data_bus,
  input wire logic [1:0] out_lcd_status,
  input wire logic [1:0] out_request_status,
  input wire logic       out_request_done
);

  // Status pair that must accompany a done pulse.
  logic done_state_ok;

  assign done_state_ok = (out_request_status == clpc_pkg::REQ_ST_DONE) &&
                         (out_lcd_status == clpc_pkg::LCD_ST_OPER);

  // The bus is only ever written.
  `CHK_IMPL(a_rw_low, out_valid, !out_read_write)

  // A done pulse only comes with done status while operational.
  `CHK_IMPL(a_done_status, out_valid && out_request_done, done_state_ok)

  // Input stalls only when the output stage holds results.
  `CHK_IMPL(a_stall_has_out, !in_ready, out_valid)

  // A stalled result holds its payload.
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data_bus) && $stable(out_request_status))

endmodule

bind char_lcd_parallel_controller_top clpc_checker u_clpc_checker (.*);

`default_nettype wire
